### rtl/cmc_pkg.sv
// Shared constants and types for the contact mask classifier.
// Holds register indexes, reason codes, reset values and size defaults.
// No dependencies.
package cmc_pkg;

   localparam int unsigned MAX_WIDTH_DEF  = 4096;
   localparam int unsigned MAX_HEIGHT_DEF = 4096;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 13;
   localparam int unsigned SIZE_W      = 13;
   localparam int unsigned BORDER_W    = 12;
   localparam int unsigned CHAN_W      = 8;

   localparam logic [SIZE_W-1:0]   FRAME_WIDTH_RST  = 13'd320;
   localparam logic [SIZE_W-1:0]   FRAME_HEIGHT_RST = 13'd240;
   localparam logic [BORDER_W-1:0] BORDER_RST       = 12'd0;
   localparam logic [CHAN_W-1:0]   MARKER_LOW_RST   = 8'd0;
   localparam logic [CHAN_W-1:0]   MARKER_HIGH_RST  = 8'd0;
   localparam logic [CHAN_W-1:0]   RISE_RST         = 8'd255;
   localparam logic [CHAN_W-1:0]   FALL_RST         = 8'd255;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_BORDER_WIDTH = 3'd2,
      CSR_MARKER_LOW   = 3'd3,
      CSR_MARKER_HIGH  = 3'd4,
      CSR_RISE_THRESH  = 3'd5,
      CSR_FALL_THRESH  = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      REASON_BORDER  = 2'd0,
      REASON_MARKER  = 2'd1,
      REASON_NO_HIT  = 2'd2,
      REASON_CONTACT = 2'd3
   } reason_type;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } rgb_type;

endpackage

### rtl/contact_mask_classifier.sv
// Top level of the contact mask classifier: position tracking, border, marker
// and contact tests on a two-register pipeline. Depends on cmc_pkg.
//
// Each input beat is one RGB pixel of a raster-ordered frame together with the
// reference pixel at the same place; req_tuser set marks the first pixel of a
// frame and restarts the position at column 0, row 0. Every input beat yields
// exactly one result beat carrying a contact bit and a reason code (border,
// marker, no contact, contact). The block takes one pixel per clock; a result
// beat is offered once its pixel has passed from the input register into the
// result register, and throughput drops only while rsp_tready is held low,
// since the input register and the result register form the whole pipeline.
// Frame sizes of zero act as one, sizes above MAX_WIDTH or MAX_HEIGHT act as
// that limit, and configuration writes are always accepted and must be made while no pixel is in flight.
module contact_mask_classifier #(
   parameter int unsigned MAX_WIDTH  = cmc_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = cmc_pkg::MAX_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // cur_blue, cur_green, cur_red, ref_blue, ref_green, ref_red (8 bits each)
   input  logic [47:0]                      req_tdata,
   // first_pixel
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // contact (bit 0), reason (bits 2:1), zero fill (bits 7:3)
   output logic [7:0]                       rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cmc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cmc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import cmc_pkg::*;

   localparam int unsigned CW   = $clog2(MAX_WIDTH);
   localparam int unsigned RW   = $clog2(MAX_HEIGHT);
   localparam int unsigned PW   = (CW > RW) ? CW : RW;
   localparam int unsigned CMPW = ((PW > SIZE_W) ? PW : SIZE_W) + 1;
   localparam logic [CMPW-1:0] MAX_W_C = CMPW'(MAX_WIDTH);
   localparam logic [CMPW-1:0] MAX_H_C = CMPW'(MAX_HEIGHT);

   function automatic logic [CMPW-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                  input logic [CMPW-1:0]   mx);
      logic [CMPW-1:0] vx;
      vx = CMPW'(v);
      if (vx == '0) begin
         return CMPW'(1);
      end else if (vx > mx) begin
         return mx;
      end
      return vx;
   endfunction

   function automatic logic [CHAN_W-1:0] max3(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b,
                                              input logic [CHAN_W-1:0] c);
      logic [CHAN_W-1:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   function automatic logic [CHAN_W-1:0] min3(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b,
                                              input logic [CHAN_W-1:0] c);
      logic [CHAN_W-1:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic logic [CHAN_W-1:0] pos_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      return (a >= b) ? CHAN_W'(a - b) : '0;
   endfunction

   // Configuration registers; sizes are stored already clamped.
   logic [CMPW-1:0]     width_ff;
   logic [CMPW-1:0]     height_ff;
   logic [BORDER_W-1:0] border_ff;
   logic [CHAN_W-1:0]   marker_low_ff;
   logic [CHAN_W-1:0]   marker_high_ff;
   logic [CHAN_W-1:0]   rise_thresh_ff;
   logic [CHAN_W-1:0]   fall_thresh_ff;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic    s1_valid_ff;
   logic    s1_first_ff;
   rgb_type s1_cur_ff;
   rgb_type s1_ref_ff;

   logic       out_valid_ff;
   logic       out_contact_ff, out_contact_in;
   reason_type out_reason_ff, out_reason_in;

   logic out_advance;
   logic s1_advance;
   logic req_accept;

   assign csr_ready   = 1'b1;
   assign out_advance = !out_valid_ff || rsp_tready;
   assign s1_advance  = s1_valid_ff && out_advance;
   assign req_tready  = !s1_valid_ff || out_advance;
   assign req_accept  = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= clamp_size(FRAME_WIDTH_RST, MAX_W_C);
         height_ff      <= clamp_size(FRAME_HEIGHT_RST, MAX_H_C);
         border_ff      <= BORDER_RST;
         marker_low_ff  <= MARKER_LOW_RST;
         marker_high_ff <= MARKER_HIGH_RST;
         rise_thresh_ff <= RISE_RST;
         fall_thresh_ff <= FALL_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  width_ff       <= clamp_size(csr_data, MAX_W_C);
            CSR_FRAME_HEIGHT: height_ff      <= clamp_size(csr_data, MAX_H_C);
            CSR_BORDER_WIDTH: border_ff      <= csr_data[BORDER_W-1:0];
            CSR_MARKER_LOW:   marker_low_ff  <= csr_data[CHAN_W-1:0];
            CSR_MARKER_HIGH:  marker_high_ff <= csr_data[CHAN_W-1:0];
            CSR_RISE_THRESH:  rise_thresh_ff <= csr_data[CHAN_W-1:0];
            CSR_FALL_THRESH:  fall_thresh_ff <= csr_data[CHAN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_first_ff     <= req_tuser;
         s1_cur_ff.blue  <= req_tdata[7:0];
         s1_cur_ff.green <= req_tdata[15:8];
         s1_cur_ff.red   <= req_tdata[23:16];
         s1_ref_ff.blue  <= req_tdata[31:24];
         s1_ref_ff.green <= req_tdata[39:32];
         s1_ref_ff.red   <= req_tdata[47:40];
      end
   end

   // Classification and position advance for the pixel in the input register.
   logic [CW-1:0]     pos_col;
   logic [RW-1:0]     pos_row;
   logic [CMPW-1:0]   col_x, row_x, bord_x;
   logic              in_region;
   logic [CHAN_W-1:0] cur_max, cur_min, rise_max, fall_max;

   always_comb begin
      pos_col   = s1_first_ff ? '0 : col_ff;
      pos_row   = s1_first_ff ? '0 : row_ff;
      col_x     = CMPW'(pos_col);
      row_x     = CMPW'(pos_row);
      bord_x    = CMPW'(border_ff);
      in_region = (col_x >= bord_x) && (CMPW'(col_x + bord_x) < width_ff) &&
                  (row_x >= bord_x) && (CMPW'(row_x + bord_x) < height_ff);
      cur_max  = max3(s1_cur_ff.blue, s1_cur_ff.green, s1_cur_ff.red);
      cur_min  = min3(s1_cur_ff.blue, s1_cur_ff.green, s1_cur_ff.red);
      rise_max = max3(pos_diff(s1_cur_ff.blue,  s1_ref_ff.blue),
                      pos_diff(s1_cur_ff.green, s1_ref_ff.green),
                      pos_diff(s1_cur_ff.red,   s1_ref_ff.red));
      fall_max = max3(pos_diff(s1_ref_ff.blue,  s1_cur_ff.blue),
                      pos_diff(s1_ref_ff.green, s1_cur_ff.green),
                      pos_diff(s1_ref_ff.red,   s1_cur_ff.red));

      out_contact_in = 1'b0;
      if (!in_region) begin
         out_reason_in = REASON_BORDER;
      end else if (cur_min < marker_low_ff && cur_max < marker_high_ff) begin
         out_reason_in = REASON_MARKER;
      end else if (rise_max >= rise_thresh_ff && fall_max >= fall_thresh_ff) begin
         out_reason_in  = REASON_CONTACT;
         out_contact_in = 1'b1;
      end else begin
         out_reason_in = REASON_NO_HIT;
      end

      if (CMPW'(col_x + 1'b1) >= width_ff) begin
         col_in = '0;
         row_in = (CMPW'(row_x + 1'b1) >= height_ff) ? '0 : RW'(row_x + 1'b1);
      end else begin
         col_in = CW'(col_x + 1'b1);
         row_in = pos_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (s1_advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_contact_ff <= out_contact_in;
         out_reason_ff  <= out_reason_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b00000, out_reason_ff, out_contact_ff};

   // The contact bit agrees with the reason code on every result beat.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_contact_ff == (out_reason_ff == REASON_CONTACT)))
      else $error("contact bit disagrees with reason code");

   // With both pipeline registers full and the output stalled, no beat may enter.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while pipeline is full");

   // A pixel held in the input register stays there while the output stalls.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_advance) |=> (s1_valid_ff && $stable(s1_cur_ff)))
      else $error("stalled pixel lost from input register");

endmodule

### bench/contact_mask_classifier_tb.sv
// Self-checking testbench for contact_mask_classifier: directed frames, then
// random frames, checked beat by beat against a pixel classifier kept here.
// Depends on cmc_pkg and the contact_mask_classifier RTL.
module contact_mask_classifier_tb;
   import cmc_pkg::*;

   localparam int unsigned WIDTH_LIMIT  = MAX_WIDTH_DEF;
   localparam int unsigned HEIGHT_LIMIT = MAX_HEIGHT_DEF;
   localparam int unsigned QUIET_LIMIT  = 3000;

   typedef struct {
      logic       contact;
      reason_type reason;
   } mask_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [47:0]   req_tdata = '0;
   logic          req_tuser = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [7:0]    rsp_tdata;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic [SIZE_W-1:0]   width_reg  = FRAME_WIDTH_RST;
   logic [SIZE_W-1:0]   height_reg = FRAME_HEIGHT_RST;
   logic [BORDER_W-1:0] border_reg = BORDER_RST;
   logic [CHAN_W-1:0]   marker_lo  = MARKER_LOW_RST;
   logic [CHAN_W-1:0]   marker_hi  = MARKER_HIGH_RST;
   logic [CHAN_W-1:0]   rise_th    = RISE_RST;
   logic [CHAN_W-1:0]   fall_th    = FALL_RST;
   int unsigned         col_pos = 0;
   int unsigned         row_pos = 0;

   mask_result_type expected_q[$];
   int unsigned errors = 0;
   int unsigned stall_left = 0;
   int unsigned quiet_cycles = 0;
   bit          pix_gaps_on = 1'b1;
   bit          rsp_stalls_on = 1'b1;

   contact_mask_classifier #(
      .MAX_WIDTH  (WIDTH_LIMIT),
      .MAX_HEIGHT (HEIGHT_LIMIT)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic mask_result_type classify_pixel(input logic first, input logic [47:0] pix);
      int unsigned w, h, b, lo, hi, up_max, down_max, c, r;
      bit          in_region;
      mask_result_type res;
      w = (width_reg == 0) ? 1 : ((width_reg > WIDTH_LIMIT) ? WIDTH_LIMIT : width_reg);
      h = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg);
      b = border_reg;
      if (first) begin
         col_pos = 0;
         row_pos = 0;
      end
      in_region = col_pos >= b && col_pos + b < w && row_pos >= b && row_pos + b < h;
      res.contact = 1'b0;
      res.reason  = REASON_BORDER;
      if (in_region) begin
         lo = 255;
         hi = 0;
         up_max = 0;
         down_max = 0;
         for (int i = 0; i < 3; i++) begin
            c = pix[8*i +: 8];
            r = pix[24 + 8*i +: 8];
            if (c < lo) lo = c;
            if (c > hi) hi = c;
            if (c >= r && c - r > up_max) up_max = c - r;
            if (c < r && r - c > down_max) down_max = r - c;
         end
         if (lo < marker_lo && hi < marker_hi) begin
            res.reason = REASON_MARKER;
         end else if (up_max >= rise_th && down_max >= fall_th) begin
            res.contact = 1'b1;
            res.reason  = REASON_CONTACT;
         end else begin
            res.reason = REASON_NO_HIT;
         end
      end
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return res;
   endfunction

   function automatic logic [47:0] pack_pixel(input logic [7:0] cb, cg, cr, rb, rg, rr);
      return {rr, rg, rb, cr, cg, cb};
   endfunction

   function automatic logic [47:0] make_random_pixel();
      logic [47:0] pix;
      int          c, r;
      int unsigned kind;
      kind = $urandom_range(0, 9);
      pix[31:0]  = $urandom;
      pix[47:32] = 16'($urandom_range(0, 65535));
      if (kind >= 2) begin
         for (int i = 0; i < 3; i++) begin
            r = $urandom_range(0, 255);
            if (kind < 4) begin
               c = $urandom_range(0, marker_hi);
            end else begin
               case ($urandom_range(0, 2))
                  0: c = r + int'(rise_th) + int'($urandom_range(0, 2)) - 1;
                  1: c = r - int'(fall_th) + int'($urandom_range(0, 2)) - 1;
                  default: c = $urandom_range(0, 255);
               endcase
            end
            if (c < 0) c = 0;
            if (c > 255) c = 255;
            pix[8*i +: 8]      = 8'(c);
            pix[24 + 8*i +: 8] = 8'(r);
         end
      end
      return pix;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (!pix_gaps_on || roll > 5) return 0;
      if (roll == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic int unsigned pick_size();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return 0;
      if (roll == 1) return $urandom_range(4096, 8191);
      if (roll == 2) return 1;
      return $urandom_range(2, 12);
   endfunction

   function automatic int unsigned pick_border();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return $urandom_range(2048, 4095);
      if (roll == 1) return 2048;
      return $urandom_range(0, 3);
   endfunction

   function automatic int unsigned pick_threshold();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 0;
      if (roll == 1) return 255;
      return $urandom_range(0, 255);
   endfunction

   task automatic send_pixel(input logic first, input logic [47:0] pix);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= first;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      expected_q.push_back(classify_pixel(first, pix));
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Results leave through the input and result registers, so once every expected
   // result has arrived and a short pause has passed the pipeline is empty.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH:  width_reg  = value[SIZE_W-1:0];
         CSR_FRAME_HEIGHT: height_reg = value[SIZE_W-1:0];
         CSR_BORDER_WIDTH: border_reg = value[BORDER_W-1:0];
         CSR_MARKER_LOW:   marker_lo  = value[CHAN_W-1:0];
         CSR_MARKER_HIGH:  marker_hi  = value[CHAN_W-1:0];
         CSR_RISE_THRESH:  rise_th    = value[CHAN_W-1:0];
         CSR_FALL_THRESH:  fall_th    = value[CHAN_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic check_result(input logic [7:0] beat);
      mask_result_type want;
      if (expected_q.size() == 0) begin
         $error("result beat %0h arrived with no pixel pending", beat);
         errors++;
      end else begin
         want = expected_q.pop_front();
         if (beat[0] !== want.contact) begin
            $error("contact: expected %0d, actual %0d", want.contact, beat[0]);
            errors++;
         end
         if (beat[2:1] !== want.reason) begin
            $error("reason: expected %0d, actual %0d", want.reason, beat[2:1]);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 9) == 0) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("contact_mask_classifier_tb NOT OK");
         $finish;
      end
   end

   task automatic test_reset_defaults();
      send_pixel(1'b1, pack_pixel(8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd128));
      send_pixel(1'b0, pack_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      send_pixel(1'b0, pack_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
      send_pixel(1'b0, pack_pixel(8'd0, 8'd255, 8'd7, 8'd254, 8'd0, 8'd7));
   endtask

   task automatic test_marker_and_contact();
      drain_pipeline();
      write_reg(CSR_FRAME_WIDTH, 4);
      write_reg(CSR_FRAME_HEIGHT, 2);
      write_reg(CSR_BORDER_WIDTH, 0);
      write_reg(CSR_MARKER_LOW, 40);
      write_reg(CSR_MARKER_HIGH, 90);
      write_reg(CSR_RISE_THRESH, 30);
      write_reg(CSR_FALL_THRESH, 30);
      send_pixel(1'b1, pack_pixel(8'd10, 8'd80, 8'd39, 8'd10, 8'd80, 8'd39));
      send_pixel(1'b0, pack_pixel(8'd10, 8'd90, 8'd20, 8'd40, 8'd60, 8'd20));
      send_pixel(1'b0, pack_pixel(8'd40, 8'd50, 8'd60, 8'd41, 8'd20, 8'd60));
      send_pixel(1'b0, pack_pixel(8'd100, 8'd200, 8'd50, 8'd129, 8'd170, 8'd50));
      send_pixel(1'b0, pack_pixel(8'd100, 8'd200, 8'd50, 8'd130, 8'd171, 8'd50));
      send_pixel(1'b0, pack_pixel(8'd100, 8'd200, 8'd50, 8'd130, 8'd170, 8'd50));
      send_pixel(1'b0, pack_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
   endtask

   // A 3x3 frame with a one-pixel margin leaves only the center pixel; the
   // frame is restarted partway through to check the first-pixel flag.
   task automatic test_border_margin();
      drain_pipeline();
      write_reg(CSR_FRAME_WIDTH, 3);
      write_reg(CSR_FRAME_HEIGHT, 3);
      write_reg(CSR_BORDER_WIDTH, 1);
      for (int k = 0; k < 5; k++)
         send_pixel(k == 0, pack_pixel(8'd200, 8'd0, 8'd0, 8'd0, 8'd200, 8'd0));
      for (int k = 0; k < 9; k++)
         send_pixel(k == 0, pack_pixel(8'd200, 8'd0, 8'd0, 8'd0, 8'd200, 8'd0));
   endtask

   task automatic test_size_extremes();
      drain_pipeline();
      write_reg(CSR_FRAME_WIDTH, 0);
      write_reg(CSR_FRAME_HEIGHT, 0);
      write_reg(CSR_BORDER_WIDTH, 0);
      write_reg(CSR_MARKER_LOW, 0);
      write_reg(CSR_MARKER_HIGH, 255);
      write_reg(CSR_RISE_THRESH, 0);
      write_reg(CSR_FALL_THRESH, 0);
      send_pixel(1'b0, pack_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      send_pixel(1'b0, pack_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
      drain_pipeline();
      write_reg(CSR_FRAME_WIDTH, 4);
      write_reg(CSR_FRAME_HEIGHT, 4);
      write_reg(CSR_BORDER_WIDTH, 2);
      send_pixel(1'b1, make_random_pixel());
      send_pixel(1'b0, make_random_pixel());
      drain_pipeline();
      write_reg(CSR_FRAME_WIDTH, 4096);
      write_reg(CSR_FRAME_HEIGHT, 4096);
      write_reg(CSR_BORDER_WIDTH, 4095);
      send_pixel(1'b1, make_random_pixel());
      drain_pipeline();
      write_reg(CSR_FRAME_WIDTH, 6);
      write_reg(CSR_FRAME_HEIGHT, 1);
      write_reg(CSR_BORDER_WIDTH, 0);
      for (int k = 0; k < 4; k++)
         send_pixel(k == 0, make_random_pixel());
      // Shrinking the row leaves the position beyond the frame.
      drain_pipeline();
      write_reg(CSR_FRAME_WIDTH, 2);
      send_pixel(1'b0, make_random_pixel());
      send_pixel(1'b0, make_random_pixel());
   endtask

   // An oversized width is held at its limit, so the start of a long row stays in
   // row 0 and is all classed as border by the margin.
   task automatic test_oversized_width();
      drain_pipeline();
      write_reg(CSR_FRAME_WIDTH, 8191);
      write_reg(CSR_FRAME_HEIGHT, 3);
      write_reg(CSR_BORDER_WIDTH, 1);
      write_reg(CSR_MARKER_LOW, 30);
      write_reg(CSR_MARKER_HIGH, 80);
      write_reg(CSR_RISE_THRESH, 40);
      write_reg(CSR_FALL_THRESH, 40);
      pix_gaps_on = 1'b0;
      for (int k = 0; k < 64; k++)
         send_pixel(k == 0, make_random_pixel());
      pix_gaps_on = 1'b1;
   endtask

   task automatic test_random_frames();
      int unsigned sent;
      int unsigned count;
      sent = 0;
      while (sent < 1550) begin
         drain_pipeline();
         if ($urandom_range(0, 1)) write_reg(CSR_FRAME_WIDTH, pick_size());
         if ($urandom_range(0, 1)) write_reg(CSR_FRAME_HEIGHT, pick_size());
         if ($urandom_range(0, 1)) write_reg(CSR_BORDER_WIDTH, pick_border());
         if ($urandom_range(0, 1)) write_reg(CSR_MARKER_LOW, pick_threshold());
         if ($urandom_range(0, 1)) write_reg(CSR_MARKER_HIGH, pick_threshold());
         if ($urandom_range(0, 1)) write_reg(CSR_RISE_THRESH, pick_threshold());
         if ($urandom_range(0, 1)) write_reg(CSR_FALL_THRESH, pick_threshold());
         pix_gaps_on   = $urandom_range(0, 3) != 0;
         rsp_stalls_on = $urandom_range(0, 3) != 0;
         count = $urandom_range(20, 150);
         for (int k = 0; k < count; k++)
            send_pixel((k == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 49) == 0,
                       make_random_pixel());
         sent += count;
      end
      pix_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_marker_and_contact();
      test_border_margin();
      test_size_extremes();
      test_oversized_width();
      test_random_frames();
      drain_pipeline();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("contact_mask_classifier_tb OK");
      end else begin
         $display("contact_mask_classifier_tb NOT OK");
      end
      $finish;
   end

endmodule

### contact_mask_classifier.f
rtl/cmc_pkg.sv
rtl/contact_mask_classifier.sv
bench/contact_mask_classifier_tb.sv
